### rtl/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types and constants of the 3x3 RGB box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

    localparam int PIX_W      = 8;
    localparam int RGB_W      = 3 * PIX_W;
    localparam int LANES      = 3;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int TOTAL_W    = 2 * CFG_W;
    localparam int SUM_W      = 12;   // 9 * 255 fits
    localparam int CNT_W      = 4;    // up to 9 neighbors
    localparam int DIV_BITS   = SUM_W + 1;
    localparam int DEN_W      = CNT_W + 1;
    localparam int REM_W      = DEN_W + 1;
    localparam int DIV_CNT_W  = 4;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

    // neighbor offset codes along one axis
    localparam logic [1:0] TAP_MINUS = 2'd0;
    localparam logic [1:0] TAP_MID   = 2'd1;
    localparam logic [1:0] TAP_PLUS  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_CENTER,
        ST_TAPS,
        ST_FLUSH,
        ST_DIV
    } state_t;

    typedef struct packed {
        logic               restart;
        logic [CFG_W-1:0]   width;
        logic [CFG_W-1:0]   height;
        logic [TOTAL_W-1:0] total;
    } frame_cfg_t;

    typedef struct packed {
        logic take;
        logic center;
        logic tap;
        logic div_load;
        logic emit;
    } bb3_cmd_t;

    typedef struct packed {
        logic want_emit;
        logic tap_last;
        logic taps_busy;
        logic div_done;
        logic out_free;
    } bb3_stat_t;

endpackage

### rtl/bb3_cfg.sv
// ----------------------------------------------------------------------------
// bb3_cfg
// Frame size registers, clamped sizes and registered pixel count per frame.
// ----------------------------------------------------------------------------
module bb3_cfg
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output frame_cfg_t           frame
);

    logic [CFG_W-1:0]   width_raw_reg;
    logic [CFG_W-1:0]   width_raw_next;
    logic [CFG_W-1:0]   height_raw_reg;
    logic [CFG_W-1:0]   height_raw_next;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    logic [CFG_W-1:0]   eff_w;
    logic [CFG_W-1:0]   eff_h;
    logic               restart;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_raw_reg  <= FRAME_WIDTH_RST;
            height_raw_reg <= FRAME_HEIGHT_RST;
            total_reg      <= '0;
        end
        else
        begin
            width_raw_reg  <= width_raw_next;
            height_raw_reg <= height_raw_next;
            total_reg      <= total_next;
        end
    end

    always_comb
    begin
        width_raw_next  = width_raw_reg;
        height_raw_next = height_raw_reg;
        restart         = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:
                begin
                    width_raw_next = cfg_wdata;
                    restart        = 1'b1;
                end
                REG_FRAME_HEIGHT:
                begin
                    height_raw_next = cfg_wdata;
                    restart         = 1'b1;
                end
                default: restart = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        if (width_raw_reg == '0)
            eff_w = CFG_W'(1);
        else if ({20'd0, width_raw_reg} > 32'(MAX_WIDTH))
            eff_w = CFG_W'(MAX_WIDTH);
        else
            eff_w = width_raw_reg;
        eff_h = (height_raw_reg == '0) ? CFG_W'(1) : height_raw_reg;
    end

    assign total_next = TOTAL_W'(eff_w) * TOTAL_W'(eff_h);

    assign frame.restart = restart;
    assign frame.width   = eff_w;
    assign frame.height  = eff_h;
    assign frame.total   = total_reg;

endmodule

### rtl/bb3_ctrl.sv
// ----------------------------------------------------------------------------
// bb3_ctrl
// Sequencer: takes an item, decides on a result, walks the taps and divide.
// ----------------------------------------------------------------------------
module bb3_ctrl
    import bb3_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_axis_tvalid,
    output logic      s_axis_tready,
    input  bb3_stat_t stat,
    output bb3_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = stat.want_emit ? ST_CENTER : ST_IDLE;
            end
            ST_CENTER:
            begin
                cmd.center = 1'b1;
                state_next = ST_TAPS;
            end
            ST_TAPS:
            begin
                cmd.tap = 1'b1;
                if (stat.tap_last)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                // wait for the read pipe to drain into the sums
                if (!stat.taps_busy)
                begin
                    cmd.div_load = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (stat.div_done && stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### rtl/bb3_div.sv
// ----------------------------------------------------------------------------
// bb3_div
// Three-lane restoring divider, one quotient bit per cycle, shared divisor.
// ----------------------------------------------------------------------------
module bb3_div
    import bb3_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  logic [LANES-1:0][DIV_BITS-1:0] numer,
    input  logic [DEN_W-1:0]               denom,
    output logic [LANES-1:0][PIX_W-1:0]    quot,
    output logic                           done
);

    logic [DIV_CNT_W-1:0]               step_reg;
    logic [LANES-1:0][DIV_BITS-1:0]     num_reg;
    logic [LANES-1:0][DIV_BITS-1:0]     num_next;
    logic [LANES-1:0][REM_W-1:0]        rem_reg;
    logic [LANES-1:0][REM_W-1:0]        rem_next;
    logic [DEN_W-1:0]                   den_reg;

    assign done = (step_reg == DIV_CNT_W'(DIV_BITS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= DIV_CNT_W'(DIV_BITS);
        else if (load)
            step_reg <= '0;
        else if (!done)
            step_reg <= step_reg + DIV_CNT_W'(1);
    end

    // numerator register shifts out dividend bits and takes in quotient bits
    always_comb
    begin
        logic [REM_W-1:0] trial;
        logic             ge;
        for (int l = 0; l < LANES; l++)
        begin
            trial       = {rem_reg[l][REM_W-2:0], num_reg[l][DIV_BITS-1]};
            ge          = (trial >= {1'b0, den_reg});
            rem_next[l] = ge ? (trial - {1'b0, den_reg}) : trial;
            num_next[l] = {num_reg[l][DIV_BITS-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            num_reg <= numer;
            rem_reg <= '0;
            den_reg <= denom;
        end
        else if (!done)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            quot[l] = num_reg[l][PIX_W-1:0];
    end

endmodule

### rtl/bb3_dpath.sv
// ----------------------------------------------------------------------------
// bb3_dpath
// Pixel history store, position counters, tap address/sum pipe and output.
// ----------------------------------------------------------------------------
module bb3_dpath
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  frame_cfg_t       frame,
    input  bb3_cmd_t         cmd,
    output bb3_stat_t        stat,
    input  logic [RGB_W-1:0] s_axis_tdata,
    input  logic             s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [RGB_W-1:0] m_axis_tdata,
    output logic             m_axis_tlast
);

    localparam int DEPTH  = 2 * MAX_WIDTH + 4;
    localparam int AW     = $clog2(DEPTH);
    localparam int PEND_W = $clog2(MAX_WIDTH + 3);
    localparam int CMP_W  = ((PEND_W > CFG_W) ? PEND_W : CFG_W) + 1;
    localparam int SA_W   = AW + 2;
    localparam logic signed [SA_W-1:0] DEPTH_S = SA_W'(DEPTH);

    logic [RGB_W-1:0] mem [DEPTH];

    // control state
    logic [AW-1:0]      wp_reg;
    logic [PEND_W-1:0]  pend_reg;
    logic [TOTAL_W-1:0] emit_idx_reg;
    logic [CFG_W-1:0]   row_reg;
    logic [CFG_W-1:0]   col_reg;
    logic               kind_reg;
    logic [1:0]         dr_reg;
    logic [1:0]         dc_reg;
    logic               v1_reg;
    logic               v2_reg;
    logic               out_valid_reg;

    // payload
    logic [AW-1:0]      center_reg;
    logic [AW-1:0]      addr_reg;
    logic               ok1_reg;
    logic               ok2_reg;
    logic [RGB_W-1:0]   rd_reg;
    logic [SUM_W-1:0]   sum_r_reg;
    logic [SUM_W-1:0]   sum_g_reg;
    logic [SUM_W-1:0]   sum_b_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [RGB_W-1:0]   out_data_reg;
    logic               out_last_reg;

    logic               take_px;
    logic               e_last;
    logic               out_free;
    logic [AW:0]        diff;
    logic [AW-1:0]      center_next;
    logic [AW-1:0]      tap_addr;
    logic               tap_ok;
    logic [CMP_W-1:0]   pend_x;
    logic [TOTAL_W:0]   seen_x;

    logic [LANES-1:0][DIV_BITS-1:0] numer;
    logic [DEN_W-1:0]               denom;
    logic [LANES-1:0][PIX_W-1:0]    quot;
    logic                           div_done;

    assign take_px  = cmd.take && !s_axis_tuser;
    assign e_last   = (emit_idx_reg == frame.total - TOTAL_W'(1));
    assign out_free = !out_valid_reg || m_axis_tready;

    // pixels of the result's frame received so far, for the drain rule
    assign pend_x = CMP_W'(pend_reg);
    assign seen_x = (TOTAL_W + 1)'(pend_reg) + (TOTAL_W + 1)'(emit_idx_reg);

    always_comb
    begin
        stat.want_emit = kind_reg
            ? ((pend_reg != '0) && (seen_x >= (TOTAL_W + 1)'(frame.total)))
            : (pend_x >= CMP_W'(frame.width) + CMP_W'(2));
        stat.tap_last  = (dr_reg == TAP_PLUS) && (dc_reg == TAP_PLUS);
        stat.taps_busy = v1_reg || v2_reg;
        stat.div_done  = div_done;
        stat.out_free  = out_free;
    end

    // center slot = write pointer minus pending, modulo the store depth
    always_comb
    begin
        diff = {1'b0, wp_reg} - (AW + 1)'(pend_reg);
        if (diff[AW])
            center_next = AW'(diff + (AW + 1)'(DEPTH));
        else
            center_next = diff[AW-1:0];
    end

    always_comb
    begin
        logic signed [SA_W-1:0] w_s;
        logic signed [SA_W-1:0] roff;
        logic signed [SA_W-1:0] coff;
        logic signed [SA_W-1:0] s;
        logic                   row_ok;
        logic                   col_ok;
        w_s = SA_W'(frame.width);
        case (dr_reg)
            TAP_MINUS: roff = -w_s;
            TAP_PLUS:  roff = w_s;
            default:   roff = '0;
        endcase
        case (dc_reg)
            TAP_MINUS: coff = -SA_W'(1);
            TAP_PLUS:  coff = SA_W'(1);
            default:   coff = '0;
        endcase
        s = $signed({2'b00, center_reg}) + roff + coff;
        if (s < 0)
            tap_addr = AW'(s + DEPTH_S);
        else if (s >= DEPTH_S)
            tap_addr = AW'(s - DEPTH_S);
        else
            tap_addr = AW'(s);
        row_ok = (dr_reg == TAP_MID)
              || ((dr_reg == TAP_MINUS) && (row_reg != '0))
              || ((dr_reg == TAP_PLUS) && (row_reg != frame.height - CFG_W'(1)));
        col_ok = (dc_reg == TAP_MID)
              || ((dc_reg == TAP_MINUS) && (col_reg != '0))
              || ((dc_reg == TAP_PLUS) && (col_reg != frame.width - CFG_W'(1)));
        tap_ok = row_ok && col_ok;
    end

    // history store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (take_px)
            mem[wp_reg] <= s_axis_tdata;
        rd_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            pend_reg     <= '0;
            emit_idx_reg <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
        end
        else if (frame.restart)
        begin
            wp_reg       <= '0;
            pend_reg     <= '0;
            emit_idx_reg <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
        end
        else
        begin
            if (take_px)
            begin
                wp_reg   <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
                pend_reg <= pend_reg + PEND_W'(1);
            end
            else if (cmd.emit)
            begin
                pend_reg <= pend_reg - PEND_W'(1);
            end
            if (cmd.emit)
            begin
                emit_idx_reg <= e_last ? '0 : emit_idx_reg + TOTAL_W'(1);
                if (col_reg == frame.width - CFG_W'(1))
                begin
                    col_reg <= '0;
                    row_reg <= (row_reg == frame.height - CFG_W'(1))
                               ? '0 : row_reg + CFG_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + CFG_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= 1'b0;
            dr_reg        <= TAP_MINUS;
            dc_reg        <= TAP_MINUS;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take)
                kind_reg <= s_axis_tuser;
            if (cmd.center)
            begin
                dr_reg <= TAP_MINUS;
                dc_reg <= TAP_MINUS;
            end
            else if (cmd.tap)
            begin
                if (dc_reg == TAP_PLUS)
                begin
                    dc_reg <= TAP_MINUS;
                    dr_reg <= dr_reg + 2'd1;
                end
                else
                begin
                    dc_reg <= dc_reg + 2'd1;
                end
            end
            v1_reg <= cmd.tap;
            v2_reg <= v1_reg;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // tap pipe: address, store read, accumulate
    always_ff @(posedge clk)
    begin
        if (cmd.center)
            center_reg <= center_next;
        if (cmd.tap)
        begin
            addr_reg <= tap_addr;
            ok1_reg  <= tap_ok;
        end
        ok2_reg <= ok1_reg;
        if (cmd.center)
        begin
            sum_r_reg <= '0;
            sum_g_reg <= '0;
            sum_b_reg <= '0;
            cnt_reg   <= '0;
        end
        else if (v2_reg && ok2_reg)
        begin
            sum_r_reg <= sum_r_reg + SUM_W'(rd_reg[PIX_W-1:0]);
            sum_g_reg <= sum_g_reg + SUM_W'(rd_reg[2*PIX_W-1:PIX_W]);
            sum_b_reg <= sum_b_reg + SUM_W'(rd_reg[3*PIX_W-1:2*PIX_W]);
            cnt_reg   <= cnt_reg + CNT_W'(1);
        end
        if (cmd.emit)
        begin
            out_data_reg <= {quot[2], quot[1], quot[0]};
            out_last_reg <= e_last;
        end
    end

    // round half up: (2*sum + count) / (2*count)
    assign numer[0] = {sum_r_reg, 1'b0} + DIV_BITS'(cnt_reg);
    assign numer[1] = {sum_g_reg, 1'b0} + DIV_BITS'(cnt_reg);
    assign numer[2] = {sum_b_reg, 1'b0} + DIV_BITS'(cnt_reg);
    assign denom    = {cnt_reg, 1'b0};

    bb3_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (cmd.div_load),
        .numer (numer),
        .denom (denom),
        .quot  (quot),
        .done  (div_done)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_x <= CMP_W'(frame.width) + CMP_W'(2))
        else $error("pending count exceeds row length plus two");

    a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(wp_reg) < DEPTH)
        else $error("write pointer outside store");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("result written over an untaken result");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_load |-> (cnt_reg != '0))
        else $error("divide started with no neighbors summed");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && e_last) |=> ((emit_idx_reg == '0) && (row_reg == '0)
                                  && (col_reg == '0)))
        else $error("position counters out of step at end of frame");

endmodule

### rtl/box_blur_3x3_rgb.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// Streaming 3x3 box blur of RGB pixels in raster order.
// ----------------------------------------------------------------------------
// Each pixel is replaced by the rounded-half-up mean of its in-frame 3x3
// neighbors (divisor 9, 6, 4 or fewer at the borders). A result comes out
// frame_width+1 items after its pixel; after the last pixel of a frame send
// frame_width+1 drain items (tuser high) to flush it, or start the next frame
// directly. Items are taken only while the block is idle; one that gives
// a result needs nine single-port reads of the pixel history store and a
// 13-step divider run, then waits until the output register is free.
// Writing either frame register restarts the stream. The history store
// holds 2*MAX_WIDTH+4 pixels and needs no clearing after reset.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // input items
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [RGB_W-1:0]     s_axis_tdata,   // in_red, in_green, in_blue
    input  logic                 s_axis_tuser,   // req_type
    // result items
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [RGB_W-1:0]     m_axis_tdata,   // out_red, out_green, out_blue
    output logic                 m_axis_tlast    // end_of_frame
);

    frame_cfg_t frame;
    bb3_cmd_t   cmd;
    bb3_stat_t  stat;

    bb3_cfg #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .frame     (frame)
    );

    bb3_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    bb3_dpath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame         (frame),
        .cmd           (cmd),
        .stat          (stat),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

### tb/sv/blur_checker.sv
// ----------------------------------------------------------------------------
// blur_checker
// Predicts the 3x3 box blur results and compares them with the result stream.
// ----------------------------------------------------------------------------
// Watches the register write port and both streams of the blur block. Every
// accepted input item runs through a pixel history of the same depth as the
// block's, and any result it yields is queued. Every accepted result is
// compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module blur_checker
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [RGB_W-1:0]     s_axis_tdata,   // in_red, in_green, in_blue
    input  logic                 s_axis_tuser,   // req_type
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [RGB_W-1:0]     m_axis_tdata,   // out_red, out_green, out_blue
    input  logic                 m_axis_tlast,   // end_of_frame
    output int                   fail_count,
    output int                   results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIST_DEPTH = 2 * MAX_WIDTH + 4;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } rgb_t;

    typedef struct packed {
        rgb_t px;
        logic eof;
    } blurred_t;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    rgb_t             pix_hist [HIST_DEPTH];
    int               hist_wr;       // next history slot
    int               px_waiting;    // pixels taken but not yet answered
    int               next_out;      // index in its frame of the next answer
    blurred_t         blurred_q [$];
    int               mismatches;

    function automatic int eff_width();
        if (width_reg == '0)
            return 1;
        if (width_reg > MAX_WIDTH)
            return MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic int eff_height();
        return (height_reg == '0) ? 1 : int'(height_reg);
    endfunction

    function automatic void restart_stream();
        hist_wr    = 0;
        px_waiting = 0;
        next_out   = 0;
    endfunction

    // mean of the in-frame neighbors of the oldest unanswered pixel
    function automatic void push_blurred(int w, int h);
        int       row;
        int       col;
        int       center;
        int       slot;
        int       cnt;
        int       sum_r;
        int       sum_g;
        int       sum_b;
        blurred_t res;
        row    = next_out / w;
        col    = next_out % w;
        center = (hist_wr + HIST_DEPTH - px_waiting) % HIST_DEPTH;
        cnt    = 0;
        sum_r  = 0;
        sum_g  = 0;
        sum_b  = 0;
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                if (row + dr >= 0 && row + dr < h && col + dc >= 0 && col + dc < w)
                begin
                    slot  = (center + HIST_DEPTH + dr * w + dc) % HIST_DEPTH;
                    sum_r += pix_hist[slot].red;
                    sum_g += pix_hist[slot].green;
                    sum_b += pix_hist[slot].blue;
                    cnt++;
                end
            end
        end
        res.px.red   = PIX_W'((2 * sum_r + cnt) / (2 * cnt));
        res.px.green = PIX_W'((2 * sum_g + cnt) / (2 * cnt));
        res.px.blue  = PIX_W'((2 * sum_b + cnt) / (2 * cnt));
        res.eof      = (next_out == w * h - 1);
        blurred_q.push_back(res);
        px_waiting--;
        next_out = (next_out + 1 >= w * h) ? 0 : next_out + 1;
    endfunction

    function automatic void take_item(logic drain, rgb_t px);
        int w;
        int h;
        w = eff_width();
        h = eff_height();
        if (!drain)
        begin
            pix_hist[hist_wr] = px;
            hist_wr = (hist_wr + 1) % HIST_DEPTH;
            px_waiting++;
            if (px_waiting >= w + 2)
                push_blurred(w, h);
        end
        // a drain only answers once the whole frame of that answer is in
        else if (px_waiting > 0 && px_waiting >= w * h - next_out)
        begin
            push_blurred(w, h);
        end
    endfunction

    function automatic void check_blurred(rgb_t got, logic got_last);
        blurred_t want;
        if (blurred_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result with none pending: r=%0d g=%0d b=%0d last=%0b",
                         $time, got.red, got.green, got.blue, got_last);
        end
        else
        begin
            want = blurred_q.pop_front();
            if (want.px.red != got.red || want.px.green != got.green ||
                want.px.blue != got.blue || want.eof != got_last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result mismatch: want r=%0d g=%0d b=%0d last=%0b, %s",
                             $time, want.px.red, want.px.green, want.px.blue, want.eof,
                             $sformatf("got r=%0d g=%0d b=%0d last=%0b",
                                       got.red, got.green, got.blue, got_last));
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            restart_stream();
            blurred_q.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:
                    begin
                        width_reg = cfg_wdata;
                        restart_stream();
                    end
                    REG_FRAME_HEIGHT:
                    begin
                        height_reg = cfg_wdata;
                        restart_stream();
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                take_item(s_axis_tuser, rgb_t'(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
                check_blurred(rgb_t'(m_axis_tdata), m_axis_tlast);
        end
        fail_count  = mismatches;
        results_due = blurred_q.size();
    end

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the 3x3 RGB box blur.
// ----------------------------------------------------------------------------
// Drives frames of pixels and drain items under a range of frame sizes, with
// random gaps on the input and random stalls on the output. A directed part
// covers extreme pixel values, ignored drains and one-pixel frames; random
// frames of small sizes follow, then a short run at an out-of-range width.
// The blur_checker instance predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import bb3_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W         = 2048;
    localparam int MAX_H         = 4095;
    localparam int ITEM_TARGET   = 1600;
    localparam int CLAMP_PIXELS  = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;

    // indexes past the register list: writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [RGB_W-1:0]     s_axis_tdata;   // in_red, in_green, in_blue
    logic                 s_axis_tuser;   // req_type
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [RGB_W-1:0]     m_axis_tdata;   // out_red, out_green, out_blue
    logic                 m_axis_tlast;   // end_of_frame

    int fail_count;
    int results_due;
    int stream_items;
    int cur_w_val;
    int cur_h_val;
    bit burst;
    bit hold_req;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    box_blur_3x3_rgb #(
        .MAX_WIDTH (MAX_W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    blur_checker #(
        .MAX_WIDTH (MAX_W)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .results_due   (results_due)
    );

    function automatic int pick_gap();
        int sel;
        if (burst)
            return 0;
        sel = $urandom_range(0, 19);
        if (sel < 10)
            return 0;
        if (sel < 18)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [RGB_W-1:0] rand_px();
        int               sel;
        logic [RGB_W-1:0] px;
        sel = $urandom_range(0, 9);
        px  = RGB_W'($urandom);
        if (sel == 0)
            px = '0;
        else if (sel == 1)
            px = '1;
        else if (sel == 2)
            for (int k = 0; k < LANES; k++)
                px[k*PIX_W +: PIX_W] = {PIX_W{px[k]}};
        return px;
    endfunction

    function automatic int eff_dim(int v, int hi);
        return (v == 0) ? 1 : ((v > hi) ? hi : v);
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input logic drain, input logic [RGB_W-1:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= drain;
        s_axis_tdata  <= data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        stream_items++;
    endtask

    task automatic send_pixels(input int n);
        for (int i = 0; i < n; i++)
            send_item(1'b0, rand_px());
    endtask

    task automatic send_drains(input int n);
        for (int i = 0; i < n; i++)
            send_item(1'b1, RGB_W'($urandom));
    endtask

    // stop offering, wait for every pending result, then let the block finish
    // any item that yields nothing
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (results_due != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_index <= idx;
        cfg_wdata <= CFG_W'(val);
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
        if (idx == REG_FRAME_WIDTH)
            cur_w_val = val % (1 << CFG_W);
        else if (idx == REG_FRAME_HEIGHT)
            cur_h_val = val % (1 << CFG_W);
    endtask

    task automatic set_frame(input int w_val, input int h_val);
        settle();
        write_reg(REG_FRAME_WIDTH, w_val);
        write_reg(REG_FRAME_HEIGHT, h_val);
    endtask

    task automatic run_directed();
        write_reg(REG_UNUSED_2, $urandom_range(0, 4095));
        write_reg(REG_UNUSED_3, $urandom_range(0, 4095));
        set_frame(3, 3);
        send_item(1'b0, 24'hFFFFFF);
        send_item(1'b0, 24'h000000);
        send_item(1'b0, 24'hFF00FF);
        send_item(1'b1, 24'hFFFFFF);      // drain mid-frame, ignored
        send_item(1'b0, 24'h00FF00);
        send_item(1'b0, 24'h010101);
        send_item(1'b0, 24'hFEFEFE);
        send_item(1'b0, 24'h0000FF);
        send_item(1'b0, 24'h7F8081);
        send_item(1'b0, 24'hFFFFFF);
        send_drains(4);
        send_item(1'b1, 24'h000000);      // nothing left to flush
        // zero width and height act as a one-pixel frame
        set_frame(0, 0);
        send_item(1'b0, 24'hA5C3FF);
        send_drains(2);
    endtask

    task automatic run_random_phase(input int phase_no);
        int w_val;
        int h_val;
        int w;
        int h;
        int sel;
        int frames;
        int total;
        int npx;
        bit pause_mid;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            w_val = 0;
        else if (sel < 3)
            w_val = $urandom_range(11, 40);
        else
            w_val = $urandom_range(1, 10);
        sel = $urandom_range(0, 19);
        if (sel == 0)
            h_val = 0;
        else if (sel == 1)
            h_val = MAX_H;
        else if (sel < 4)
            h_val = $urandom_range(7, 30);
        else
            h_val = $urandom_range(1, 6);
        if (phase_no == 0)
        begin
            w_val = 5;
            h_val = 8;
        end
        settle();
        if ($urandom_range(0, 9) == 0)
            write_reg($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3,
                      $urandom_range(0, 4095));
        sel = (phase_no == 0) ? 5 : $urandom_range(0, 5);
        if (sel == 0)
        begin
            write_reg(REG_FRAME_WIDTH, w_val);
        end
        else if (sel == 1)
        begin
            write_reg(REG_FRAME_HEIGHT, h_val);
        end
        else if (sel == 2)
        begin
            write_reg(REG_FRAME_HEIGHT, h_val);
            write_reg(REG_FRAME_WIDTH, w_val);
        end
        else
        begin
            write_reg(REG_FRAME_WIDTH, w_val);
            write_reg(REG_FRAME_HEIGHT, h_val);
        end
        w = eff_dim(cur_w_val, MAX_W);
        h = eff_dim(cur_h_val, MAX_H);
        burst     = ($urandom_range(0, 4) == 0);
        pause_mid = (phase_no == 1) || ($urandom_range(0, 9) == 0);
        // output held off for a long stretch while input keeps coming
        if (phase_no == 0)
            hold_req = 1'b1;
        frames = $urandom_range(1, 3);
        for (int f = 0; f < frames; f++)
        begin
            total = w * h;
            npx   = total;
            if (total > 200 || (f == frames - 1 && $urandom_range(0, 5) == 0))
                npx = $urandom_range(1, (total < 3 * w + 10) ? total : 3 * w + 10);
            for (int i = 0; i < npx; i++)
            begin
                if ($urandom_range(0, 24) == 0)
                    send_item(1'b1, RGB_W'($urandom));
                send_pixels(1);
                if (pause_mid && f == 0 && i == npx / 2)
                    settle();
            end
            // a cut frame ends the phase; the next register write restarts
            if (npx < total)
                break;
            if (f == frames - 1 || $urandom_range(0, 2) == 0)
            begin
                send_drains(w + 1);
                if ($urandom_range(0, 3) == 0)
                    send_item(1'b1, RGB_W'($urandom));
            end
        end
        burst = 1'b0;
    endtask

    // output side
    initial
    begin
        int run;
        int stall;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(1, 8);
                m_axis_tready <= 1'b1;
                repeat (run) @(negedge clk);
                stall = $urandom_range(0, 19);
                if (stall < 8)
                    stall = 0;
                else if (stall < 18)
                    stall = $urandom_range(1, 3);
                else
                    stall = $urandom_range(5, 40);
                if (stall > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
        end
    end

    // input side and verdict
    initial
    begin
        int phase_no;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= '0;
        cfg_wdata     <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        burst         = 1'b0;
        hold_req      = 1'b0;
        stream_items  = 0;
        cur_w_val     = int'(FRAME_WIDTH_RST);
        cur_h_val     = int'(FRAME_HEIGHT_RST);
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();

        phase_no = 0;
        while (stream_items < ITEM_TARGET)
        begin
            run_random_phase(phase_no);
            phase_no++;
        end

        // out-of-range width clamps to the widest row: too few pixels to answer
        set_frame(4095, MAX_H);
        send_pixels(CLAMP_PIXELS);

        settle();
        if (fail_count == 0 && results_due == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
